/* rtl/core/deq_pkg.sv */
// Shared types, constants and index helpers for the double-ended queue.
// No dependencies; every other file in rtl/core but deq_ram uses this package.
package deq_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP_FWD   = 3'd4,
        OP_DUMP_BWD   = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  data_out;
        logic                      last_of_run;
    } res_t;

    typedef struct packed {
        logic              busy;
        logic [CNT_W-1:0]  count;
    } stat_t;

    // Advance a ring slot with wrap.
    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(CAPACITY - 1))
            r = '0;
        else
            r = i + IDX_W'(1);
        return r;
    endfunction

    // Step a ring slot back with wrap.
    function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == '0)
            r = IDX_W'(CAPACITY - 1);
        else
            r = i - IDX_W'(1);
        return r;
    endfunction

endpackage

/* rtl/core/deq_if.sv */
// Handshake interfaces for the command and result channels.
// Depends on deq_pkg for field widths.
interface deq_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [deq_pkg::OP_W-1:0]           opcode;
    logic signed [deq_pkg::DATA_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [deq_pkg::ST_W-1:0]           status;
    logic signed [deq_pkg::DATA_W-1:0]  data_out;
    logic                               last_of_run;

    modport source (output valid, output status, output data_out, output last_of_run,
                    input ready);
    modport sink (input valid, input status, input data_out, input last_of_run,
                  output ready);
endinterface

/* rtl/core/deq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency.
module deq_ram #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/deq_ctrl.sv */
// Queue sequencer: ring indices, entry count and the read/emit loop for pop and dump.
// Depends on deq_pkg and deq_if; drives deq_ram and the result buffer.
module deq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    deq_cmd_if.sink                     cmd,
    output deq_pkg::res_t               res,
    output logic                        res_push,
    input  logic                        res_space,
    output logic                        ram_wr_en,
    output logic [deq_pkg::IDX_W-1:0]   ram_wr_addr,
    output logic [deq_pkg::DATA_W-1:0]  ram_wr_data,
    output logic                        ram_rd_en,
    output logic [deq_pkg::IDX_W-1:0]   ram_rd_addr,
    input  logic [deq_pkg::DATA_W-1:0]  ram_rd_data,
    output deq_pkg::stat_t              stat
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                     state_reg,  state_next;
    logic [deq_pkg::IDX_W-1:0]  front_reg,  front_next;
    logic [deq_pkg::IDX_W-1:0]  back_reg,   back_next;
    logic [deq_pkg::CNT_W-1:0]  count_reg,  count_next;
    logic [deq_pkg::IDX_W-1:0]  idx_reg,    idx_next;
    logic [deq_pkg::CNT_W-1:0]  remain_reg, remain_next;
    logic                       fwd_reg,    fwd_next;

    logic                       accept;
    logic                       full;
    logic                       empty;
    logic [deq_pkg::IDX_W-1:0]  front_dec;
    logic [deq_pkg::IDX_W-1:0]  back_dec;

    assign full      = (count_reg == deq_pkg::CNT_W'(deq_pkg::CAPACITY));
    assign empty     = (count_reg == '0);
    assign front_dec = deq_pkg::slot_dec(front_reg);
    assign back_dec  = deq_pkg::slot_dec(back_reg);

    assign cmd.ready = (state_reg == S_IDLE) && res_space;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        remain_next = remain_reg;
        fwd_next    = fwd_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = back_reg;
        ram_wr_data = cmd.value;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg;

        res_push        = 1'b0;
        res.status      = deq_pkg::ST_OK;
        res.data_out    = '0;
        res.last_of_run = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (deq_pkg::op_t'(cmd.opcode))
                        deq_pkg::OP_PUSH_FRONT,
                        deq_pkg::OP_PUSH_BACK:
                        begin
                            res_push = 1'b1;
                            if (full)
                            begin
                                res.status = deq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + deq_pkg::CNT_W'(1);
                                if (deq_pkg::op_t'(cmd.opcode) == deq_pkg::OP_PUSH_FRONT)
                                begin
                                    ram_wr_addr = front_dec;
                                    front_next  = front_dec;
                                end
                                else
                                begin
                                    ram_wr_addr = back_reg;
                                    back_next   = deq_pkg::slot_inc(back_reg);
                                end
                            end
                        end
                        deq_pkg::OP_POP_FRONT,
                        deq_pkg::OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_push   = 1'b1;
                                res.status = deq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                count_next  = count_reg - deq_pkg::CNT_W'(1);
                                remain_next = deq_pkg::CNT_W'(1);
                                state_next  = S_RUN;
                                if (deq_pkg::op_t'(cmd.opcode) == deq_pkg::OP_POP_FRONT)
                                begin
                                    ram_rd_addr = front_reg;
                                    front_next  = deq_pkg::slot_inc(front_reg);
                                end
                                else
                                begin
                                    ram_rd_addr = back_dec;
                                    back_next   = back_dec;
                                end
                            end
                        end
                        deq_pkg::OP_DUMP_FWD,
                        deq_pkg::OP_DUMP_BWD:
                        begin
                            if (empty)
                            begin
                                res_push   = 1'b1;
                                res.status = deq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                remain_next = count_reg;
                                state_next  = S_RUN;
                                if (deq_pkg::op_t'(cmd.opcode) == deq_pkg::OP_DUMP_FWD)
                                begin
                                    ram_rd_addr = front_reg;
                                    idx_next    = deq_pkg::slot_inc(front_reg);
                                    fwd_next    = 1'b1;
                                end
                                else
                                begin
                                    ram_rd_addr = back_dec;
                                    idx_next    = deq_pkg::slot_dec(back_dec);
                                    fwd_next    = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            // unused opcodes: drop silently
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                // emit the element last read from the store, then fetch the next one
                if (res_space)
                begin
                    res_push        = 1'b1;
                    res.data_out    = ram_rd_data;
                    res.last_of_run = (remain_reg == deq_pkg::CNT_W'(1));
                    if (remain_reg == deq_pkg::CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_reg;
                        idx_next    = fwd_reg ? deq_pkg::slot_inc(idx_reg)
                                              : deq_pkg::slot_dec(idx_reg);
                        remain_next = remain_reg - deq_pkg::CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            back_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            remain_reg <= '0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            remain_reg <= remain_next;
            fwd_reg    <= fwd_next;
        end
    end

    assign stat.busy  = (state_reg == S_RUN);
    assign stat.count = count_reg;

endmodule

/* rtl/core/deq_obuf.sv */
// Two-entry result buffer between the sequencer and the result channel.
// Depends on deq_pkg and deq_if.
module deq_obuf (
    input  logic           clk,
    input  logic           rst_n,
    input  deq_pkg::res_t  res,
    input  logic           res_push,
    output logic           res_space,
    deq_rsp_if.source      rsp
);

    deq_pkg::res_t  entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg,   fill_next;
    logic           pop;
    deq_pkg::res_t  head;

    assign res_space = (fill_reg != 2'd2);
    assign pop       = rsp.valid && rsp.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (res_push && res_space)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({res_push && res_space, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push && res_space)
        begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

    assign head            = entry_reg[rd_ptr_reg];
    assign rsp.valid       = (fill_reg != 2'd0);
    assign rsp.status      = head.status;
    assign rsp.data_out    = head.data_out;
    assign rsp.last_of_run = head.last_of_run;

endmodule

/* rtl/core/double_ended_queue_top.sv */
// Double-ended queue of signed 32-bit values held in a ring buffer RAM.
// Path: push and error results are written into the result buffer as the command is taken;
// pop and dump results pass through the registered RAM read first, then the result buffer.
// Throughput: one push command per cycle; pops and dumps read the single RAM read port
// one entry at a time and take no new command until done; a stalled result channel slows all.
// Reset: indices, count and result buffer clear at once; stored values are not cleared.
module double_ended_queue_top (
    input  logic       clk,
    input  logic       rst_n,
    deq_cmd_if.sink    cmd,
    deq_rsp_if.source  rsp
);

    // Sequencer to result buffer
    deq_pkg::res_t   res;
    logic            res_push;
    logic            res_space;
    deq_pkg::stat_t  stat;

    // Sequencer to element store
    logic                        ram_wr_en;
    logic [deq_pkg::IDX_W-1:0]   ram_wr_addr;
    logic [deq_pkg::DATA_W-1:0]  ram_wr_data;
    logic                        ram_rd_en;
    logic [deq_pkg::IDX_W-1:0]   ram_rd_addr;
    logic [deq_pkg::DATA_W-1:0]  ram_rd_data;

    // Element store: one slot per queue entry, written by pushes,
    // read by pops and dumps.
    deq_ram #(
        .DEPTH  (deq_pkg::CAPACITY),
        .WIDTH  (deq_pkg::DATA_W),
        .ADDR_W (deq_pkg::IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequencer: accepts one command transaction at a time, updates the
    // ring indices and walks the store for pops and dumps.
    deq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .res         (res),
        .res_push    (res_push),
        .res_space   (res_space),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .stat        (stat)
    );

    // Result buffer: parts the sequencer from a stalled result channel.
    deq_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_push  (res_push),
        .res_space (res_space),
        .rsp       (rsp)
    );

    // The entry count never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= deq_pkg::CNT_W'(deq_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    // A push into a queue with room grows the count by exactly one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready
            && (cmd.opcode == deq_pkg::OP_PUSH_FRONT || cmd.opcode == deq_pkg::OP_PUSH_BACK)
            && stat.count != deq_pkg::CNT_W'(deq_pkg::CAPACITY))
        |=> stat.count == $past(stat.count) + deq_pkg::CNT_W'(1))
        else $error("push did not grow the queue");

    // The sequencer never hands a result to a full buffer.
    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_space)
        else $error("result pushed into full buffer");

    // A pop from a non-empty queue makes the sequencer busy, and it then takes no command.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && !stat.busy
            && (cmd.opcode == deq_pkg::OP_POP_FRONT || cmd.opcode == deq_pkg::OP_POP_BACK)
            && stat.count != '0)
        |=> stat.busy && !cmd.ready)
        else $error("command taken during a pop");

endmodule
